>>> rtl/pkp_pkg.sv
package pkp_pkg;

	localparam int unsigned PAL_DEPTH = 4;
	localparam int unsigned IDX_W = 2;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned RGB_W = 24;
	localparam logic [IDX_W-1:0] TRANSPARENT_INDEX = 2'd3;
	localparam logic [IDX_W-1:0] LAST_SLOT = 2'd3;
	localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [RGB_W-1:0] rgb_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic frame_start;
	} pixel_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic uses_transparency;
		logic palette_overflow;
		count_t colors_used;
	} result_t;

	// Color lookup outcome for one pixel, passed from the palette to the packer.
	typedef struct packed {
		idx_t idx;
		logic transparent;
		logic overflow;
		count_t count;
	} map_t;

endpackage

>>> rtl/pkp_palette.sv
module pkp_palette (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input pkp_pkg::pixel_t pix,
	output pkp_pkg::map_t map
);

	pkp_pkg::rgb_t colors_q [pkp_pkg::PAL_DEPTH];
	pkp_pkg::count_t count_q;
	pkp_pkg::count_t eff_count;
	pkp_pkg::count_t next_count;
	pkp_pkg::rgb_t rgb;
	logic [pkp_pkg::PAL_DEPTH-1:0] hit;
	logic insert;
	pkp_pkg::idx_t hit_idx;

	assign rgb = {pix.red, pix.green, pix.blue};
	// A frame start empties the palette before this pixel is looked up.
	assign eff_count = pix.frame_start ? '0 : count_q;

	always_comb begin
		for (int i = 0; i < pkp_pkg::PAL_DEPTH; i++) begin
			hit[i] = (pkp_pkg::count_t'(i) < eff_count) && (colors_q[i] == rgb);
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = pkp_pkg::PAL_DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = pkp_pkg::idx_t'(i);
			end
		end
	end

	always_comb begin
		insert = 1'b0;
		next_count = eff_count;
		map.idx = hit_idx;
		map.transparent = 1'b0;
		map.overflow = 1'b0;
		priority if (pix.alpha == 8'd0) begin
			map.idx = pkp_pkg::TRANSPARENT_INDEX;
			map.transparent = 1'b1;
		end else if (|hit) begin
			map.idx = hit_idx;
		end else if (eff_count < pkp_pkg::FULL_COUNT) begin
			map.idx = eff_count[pkp_pkg::IDX_W-1:0];
			insert = 1'b1;
			next_count = eff_count + pkp_pkg::count_t'(1);
		end else begin
			map.idx = pkp_pkg::TRANSPARENT_INDEX;
			map.overflow = 1'b1;
		end
		map.count = next_count;
	end

	always_ff @(posedge clk) begin
		if (fire && insert) begin
			colors_q[eff_count[pkp_pkg::IDX_W-1:0]] <= rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= next_count;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pkp_pkg::FULL_COUNT)
		else $error("palette count above depth");
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && map.overflow |=> count_q == pkp_pkg::FULL_COUNT)
		else $error("overflow reported with room left in the palette");
`endif

endmodule

>>> rtl/pkp_packer.sv
module pkp_packer (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic frame_start,
	input pkp_pkg::map_t map,
	input logic result_ready,
	output logic emit,
	output logic result_valid,
	output pkp_pkg::result_t result
);

	pkp_pkg::idx_t slot_q;
	logic [5:0] acc_q;
	logic trans_q;
	logic ovf_q;
	pkp_pkg::idx_t eff_slot;
	logic [5:0] eff_acc;
	logic trans_n;
	logic ovf_n;
	logic out_valid_q;
	pkp_pkg::result_t out_q;

	// Frame start drops any partial byte and the sticky flags.
	assign eff_slot = frame_start ? '0 : slot_q;
	assign eff_acc = frame_start ? '0 : acc_q;
	assign trans_n = (!frame_start && trans_q) || map.transparent;
	assign ovf_n = (!frame_start && ovf_q) || map.overflow;
	assign emit = (eff_slot == pkp_pkg::LAST_SLOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			acc_q <= '0;
			trans_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (fire) begin
			trans_q <= trans_n;
			ovf_q <= ovf_n;
			if (emit) begin
				slot_q <= '0;
				acc_q <= '0;
			end else begin
				slot_q <= eff_slot + pkp_pkg::idx_t'(1);
				acc_q <= {eff_acc[3:0], map.idx};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_q.packed_byte <= {eff_acc, map.idx};
			out_q.uses_transparency <= trans_n;
			out_q.palette_overflow <= ovf_n;
			out_q.colors_used <= map.count;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

`ifndef NO_ASSERTIONS
	a_emit_resets_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> slot_q == '0 && acc_q == '0)
		else $error("slot not restarted after a byte was emitted");
`endif

endmodule

>>> rtl/palette_index_pixel_packer_core.sv
// Indexed-color pixel packer: each pixel transaction carries one RGBA pixel,
// which is mapped to a 2-bit palette index and packed four to a byte, the
// first pixel in bits 7:6. A pixel with alpha zero takes index 3 and sets the
// sticky transparency flag; any other pixel is compared against up to four
// learned RGB colors and an unknown color is appended. A fifth distinct
// opaque color takes index 3 and sets the sticky overflow flag without
// changing the palette. Setting frame_start on a pixel clears the palette,
// both flags and any partial byte before that pixel is handled. The block
// accepts one pixel per clock cycle while the pixel port is ready; each
// pixel is held in the input register, and the byte completed by the fourth
// pixel of a group goes on to the result register: one result transaction
// per complete group of four pixels. The four palette compares, the insert
// and the packing step all sit between the input register and the result
// register. Only a held pixel that completes a byte waits for a stalled
// result; the pixel port stays ready as long as the held pixel can move on
// in the same cycle.
module palette_index_pixel_packer_core (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	output logic pixel_ready,
	input pkp_pkg::pixel_t pixel,
	output logic result_valid,
	input logic result_ready,
	output pkp_pkg::result_t result
);

	logic valid_s1;
	pkp_pkg::pixel_t pix_s1;
	logic advance;
	logic s1_emits;
	pkp_pkg::map_t map;

	// The held pixel is processed unless it completes a byte while the result
	// register is still full and not being emptied this cycle.
	assign advance = valid_s1 && (!s1_emits || !result_valid || result_ready);
	assign pixel_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_ready && pixel_valid) begin
			pix_s1 <= pixel;
		end
	end

	pkp_palette u_palette (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.pix(pix_s1),
		.map(map)
	);

	pkp_packer u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.frame_start(pix_s1.frame_start),
		.map(map),
		.result_ready(result_ready),
		.emit(s1_emits),
		.result_valid(result_valid),
		.result(result)
	);

`ifndef NO_ASSERTIONS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pix_s1))
		else $error("held pixel lost or changed while stalled");
	a_overflow_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.palette_overflow
			|-> result.colors_used == pkp_pkg::FULL_COUNT)
		else $error("overflow flagged with a palette that is not full");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> valid_s1 && result_valid)
		else $error("pixel port stalled without a blocked result");
`endif

endmodule

>>> dv/tb_palette_index_pixel_packer_core.sv
module tb_palette_index_pixel_packer_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic pixel_valid;
	logic pixel_ready;
	pkp_pkg::pixel_t pixel;
	logic result_valid;
	logic result_ready;
	pkp_pkg::result_t result;

	palette_index_pixel_packer_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// Free-running clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Shadow copy of the block's palette and packing state. It is updated once per
	// accepted pixel transaction, in the same order as the block sees them.
	pkp_pkg::rgb_t pal_rgb [pkp_pkg::PAL_DEPTH];
	pkp_pkg::count_t pal_count;
	pkp_pkg::idx_t slot;
	logic [5:0] acc_bits;
	logic seen_transparent;
	logic seen_overflow;

	// Bytes the block still owes us, oldest first.
	pkp_pkg::result_t expected_bytes [$];

	// Idle percentages for the current phase: how often the pixel side holds
	// back a cycle and how often the result side refuses a cycle.
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	int unsigned fail_count;
	int unsigned pixels_sent;
	int unsigned bytes_checked;
	int unsigned frames_started;
	int unsigned transparent_pixels;
	int unsigned overflow_bytes;

	function automatic pkp_pkg::pixel_t make_pixel(input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [7:0] a, input logic fs);
		pkp_pkg::pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.alpha = a;
		p.frame_start = fs;
		return p;
	endfunction

	// Work out what one accepted pixel does to the state, and queue the packed
	// byte when this pixel fills the last slot of the byte.
	task automatic predict_packed_byte(input pkp_pkg::pixel_t p);
		pkp_pkg::idx_t idx;
		pkp_pkg::rgb_t rgb;
		logic hit;
		pkp_pkg::result_t r;
		if (p.frame_start) begin
			pal_count = '0;
			slot = '0;
			acc_bits = '0;
			seen_transparent = 1'b0;
			seen_overflow = 1'b0;
			frames_started++;
		end
		rgb = {p.red, p.green, p.blue};
		if (p.alpha == 8'd0) begin
			// Transparent pixels never touch the palette, whatever their RGB.
			idx = pkp_pkg::TRANSPARENT_INDEX;
			seen_transparent = 1'b1;
			transparent_pixels++;
		end else begin
			hit = 1'b0;
			idx = pkp_pkg::TRANSPARENT_INDEX;
			// Scan from the top so the lowest matching entry wins.
			for (int i = pkp_pkg::PAL_DEPTH - 1; i >= 0; i--) begin
				if (i < pal_count && pal_rgb[i] == rgb) begin
					idx = pkp_pkg::idx_t'(i);
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (pal_count < pkp_pkg::FULL_COUNT) begin
					pal_rgb[pal_count[pkp_pkg::IDX_W-1:0]] = rgb;
					idx = pal_count[pkp_pkg::IDX_W-1:0];
					pal_count = pal_count + 1'b1;
				end else begin
					// Palette is full: the color saturates to index 3.
					seen_overflow = 1'b1;
				end
			end
		end
		if (slot == pkp_pkg::LAST_SLOT) begin
			r.packed_byte = {acc_bits, idx};
			r.uses_transparency = seen_transparent;
			r.palette_overflow = seen_overflow;
			r.colors_used = pal_count;
			expected_bytes.push_back(r);
			if (seen_overflow)
				overflow_bytes++;
			acc_bits = '0;
			slot = '0;
		end else begin
			acc_bits = {acc_bits[3:0], idx};
			slot = slot + 1'b1;
		end
	endtask

	// Present one pixel transaction and hold it until the block takes it. After
	// acceptance the sender may go idle, per the phase setting.
	task automatic push_pixel(input pkp_pkg::pixel_t p);
		pixel_valid <= 1'b1;
		pixel <= p;
		do
			@(posedge clk);
		while (!pixel_ready);
		predict_packed_byte(p);
		pixels_sent++;
		if ($urandom_range(99, 0) < sender_idle_pct) begin
			pixel_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99, 0) < sender_idle_pct);
		end
	endtask

	// Hold the pixel side off until every owed byte has come back, then let the
	// two-stage pipe settle.
	task automatic wait_for_drain();
		pixel_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_result(input pkp_pkg::result_t got);
		pkp_pkg::result_t want;
		if (expected_bytes.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected result transaction, byte=%02h t=%0b o=%0b n=%0d",
					$realtime, got.packed_byte, got.uses_transparency,
					got.palette_overflow, got.colors_used);
		end else begin
			want = expected_bytes.pop_front();
			bytes_checked++;
			if (got.packed_byte !== want.packed_byte
				|| got.uses_transparency !== want.uses_transparency
				|| got.palette_overflow !== want.palette_overflow
				|| got.colors_used !== want.colors_used) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: byte %0d wrong: exp byte=%02h t=%0b o=%0b n=%0d,",
						$realtime, bytes_checked, want.packed_byte,
						want.uses_transparency, want.palette_overflow,
						want.colors_used, " got byte=%02h t=%0b o=%0b n=%0d",
						got.packed_byte, got.uses_transparency,
						got.palette_overflow, got.colors_used);
			end
		end
	endtask

	// Result side: check each accepted result transaction against the oldest
	// owed byte, and pick the ready level for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				check_result(result);
			result_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
		end
	end

	// Extremes of every channel in one byte: black, white, white at the lowest
	// opaque alpha (same color as white, so it reuses entry 1), and a transparent
	// white pixel that must not join the palette.
	task automatic test_channel_extremes();
		push_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b1));
		push_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
		push_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h01, 1'b0));
		push_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h00, 1'b0));
	endtask

	// Fill the palette, then push a fifth color past it. The second byte mixes
	// the overflow case with a transparent pixel and an opaque match on entry 3,
	// all three giving index 3, and ends with entry 0 at a different alpha to
	// show that alpha plays no part in matching.
	task automatic test_palette_full();
		push_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h80, 1'b1));
		push_pixel(make_pixel(8'h12, 8'h34, 8'h57, 8'h80, 1'b0));
		push_pixel(make_pixel(8'h92, 8'h34, 8'h56, 8'h80, 1'b0));
		push_pixel(make_pixel(8'h12, 8'hb4, 8'h56, 8'h80, 1'b0));
		push_pixel(make_pixel(8'hfe, 8'h01, 8'h7f, 8'h40, 1'b0));
		push_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		push_pixel(make_pixel(8'h12, 8'hb4, 8'h56, 8'hff, 1'b0));
		push_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h01, 1'b0));
	endtask

	// A frame start in the middle of a byte must throw away the gathered slots,
	// the palette and both sticky flags before it handles its own pixel.
	task automatic test_frame_start_mid_byte();
		push_pixel(make_pixel(8'h55, 8'haa, 8'h55, 8'h00, 1'b1));
		push_pixel(make_pixel(8'haa, 8'h55, 8'haa, 8'h7f, 1'b0));
		push_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'hfe, 1'b1));
		push_pixel(make_pixel(8'h80, 8'h80, 8'h80, 8'h80, 1'b0));
		push_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'h10, 1'b0));
		push_pixel(make_pixel(8'hc0, 8'hc0, 8'hc0, 8'h20, 1'b0));
	endtask

	// Random images. Each frame draws a handful of colors and mostly repeats
	// them, so that matches, palette fills and overflow all come up often; a
	// share of pixels are transparent or carry an arbitrary color as noise.
	task automatic test_random_frames(input int unsigned n_pixels,
		input int unsigned idle_pct, input int unsigned stall_pct);
		pkp_pkg::rgb_t colors [6];
		int unsigned n_colors;
		int unsigned frame_len;
		int unsigned kind;
		int unsigned sent;
		pkp_pkg::rgb_t rgb;
		logic [7:0] a;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_pixels) begin
			n_colors = $urandom_range(6, 1);
			for (int k = 0; k < 6; k++) begin
				case ($urandom_range(7, 0))
					0: colors[k] = 24'h000000;
					1: colors[k] = 24'hffffff;
					default: colors[k] = pkp_pkg::rgb_t'($urandom);
				endcase
			end
			frame_len = $urandom_range(48, 1);
			for (int j = 0; j < frame_len && sent < n_pixels; j++) begin
				kind = $urandom_range(99, 0);
				rgb = colors[$urandom_range(n_colors - 1, 0)];
				if (kind < 12) begin
					a = 8'h00;
					if ($urandom_range(1, 0))
						rgb = pkp_pkg::rgb_t'($urandom);
				end else if (kind < 22) begin
					rgb = pkp_pkg::rgb_t'($urandom);
					a = 8'($urandom_range(255, 1));
				end else begin
					a = $urandom_range(1, 0) ? 8'hff : 8'($urandom_range(255, 1));
				end
				push_pixel(make_pixel(rgb[23:16], rgb[15:8], rgb[7:0], a, j == 0));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_ready = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		fail_count = 0;
		pixels_sent = 0;
		bytes_checked = 0;
		frames_started = 0;
		transparent_pixels = 0;
		overflow_bytes = 0;
		pal_count = '0;
		slot = '0;
		acc_bits = '0;
		seen_transparent = 1'b0;
		seen_overflow = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_channel_extremes();
		test_palette_full();
		test_frame_start_mid_byte();
		// The pixel side pauses here until every owed byte is back.
		wait_for_drain();

		test_random_frames(350, 0, 0);
		test_random_frames(350, 61, 0);
		test_random_frames(350, 0, 61);
		test_random_frames(350, 38, 38);
		wait_for_drain();

		$display("Covered %0d pixels in %0d frames (%0d transparent); %0d bytes checked,",
			pixels_sent, frames_started, transparent_pixels, bytes_checked);
		$display("%0d of them with the palette overflow flag set; %0d failures.",
			overflow_bytes, fail_count + expected_bytes.size());
		if (fail_count == 0 && expected_bytes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#1600000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pkp_pkg.sv
rtl/pkp_palette.sv
rtl/pkp_packer.sv
rtl/palette_index_pixel_packer_core.sv
dv/tb_palette_index_pixel_packer_core.sv
